@@ sv/texture_sampler_filter_macros.svh @@
// Assertion macros shared by the texture sampler RTL.
`ifndef TEXTURE_SAMPLER_FILTER_MACROS_SVH
`define TEXTURE_SAMPLER_FILTER_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define TSF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TSF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ sv/tsf_pkg.sv @@
// Shared constants and types for the texture sampler.
package tsf_pkg;
  localparam int TexelDepth = 4096;
  localparam int TexelBits = 16;
  localparam int FracBits = 8;
  localparam int AddrBits = $clog2(TexelDepth);
  localparam int CoordBits = 20;
  localparam int IntBits = CoordBits - FracBits;
  localparam int SizeBits = 13;
  localparam int WeightBits = 8;

  localparam logic CmdWrite = 1'b0;
  localparam logic CmdSample = 1'b1;

  localparam logic [1:0] RegWidth = 2'd0;
  localparam logic [1:0] RegHeight = 2'd1;
  localparam logic [1:0] RegLinear = 2'd2;
  localparam logic [1:0] RegTwoDim = 2'd3;

  typedef logic [AddrBits-1:0] addr_t;
  typedef logic signed [TexelBits-1:0] texel_t;
  typedef logic [WeightBits:0] weight_t;

  // Mode bits that travel down the pipeline with a sample.
  typedef struct packed {
    logic linear;
    logic two_dim;
  } mode_t;

  function automatic addr_t sat_addr(input logic [31:0] a);
    if (a > 32'(TexelDepth - 1)) return addr_t'(TexelDepth - 1);
    return addr_t'(a);
  endfunction

  function automatic logic [CoordBits-1:0] half_back(input logic [CoordBits-1:0] c);
    localparam logic [CoordBits-1:0] Half = CoordBits'(1) << (FracBits - 1);
    return (c > Half) ? c - Half : '0;
  endfunction

  function automatic weight_t weight_of(input logic [FracBits-1:0] f);
    if (FracBits > WeightBits)
      return weight_t'(({1'b0, f} + (1 << (FracBits - WeightBits - 1)))
                       >> (FracBits - WeightBits));
    return weight_t'(f) << (WeightBits - FracBits);
  endfunction

  function automatic logic [SizeBits-1:0] next_of(input logic [IntBits-1:0] i,
                                                 input logic [SizeBits-1:0] size);
    logic [SizeBits-1:0] last;
    logic [SizeBits:0] inc;
    last = (size == '0) ? '0 : size - 1'b1;
    inc = (SizeBits+1)'(i) + 1'b1;
    return (inc < {1'b0, last}) ? inc[SizeBits-1:0] : last;
  endfunction
endpackage

@@ sv/texture_sampler_filter.sv @@
// Texture sampler top level: texel store plus pipelined bilinear filter.
// Pipeline: stage 1, stage 2, the store read, stage 4, then stage 5 into the output
// register; throughput is one transaction per cycle while the output is not stalled.
// Four store read ports (one copy of the store per bilinear tap) set the rate.
// Reset (rst, synchronous) clears valid bits and returns config to its defaults; store contents stay
// undefined until written.
`include "texture_sampler_filter_macros.svh"
module texture_sampler_filter
  import tsf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd, texel_index[12:1], texel_value[28:13], coord_x[48:29], coord_y[68:49]
  input  logic [71:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // sample_value[15:0]
  output logic [15:0] m_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  logic [SizeBits-1:0] tex_width, tex_height;
  logic linear_filter, two_dimensional;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      tex_width <= SizeBits'(1);
      tex_height <= SizeBits'(1);
      linear_filter <= 1'b0;
      two_dimensional <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegWidth: tex_width <= cfg_data[SizeBits-1:0];
        RegHeight: tex_height <= cfg_data[SizeBits-1:0];
        RegLinear: linear_filter <= cfg_data[0];
        RegTwoDim: two_dimensional <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pipeline advances unless the output register holds an untaken result.
  logic adv;
  assign adv = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic in_cmd;
  logic [AddrBits-1:0] in_idx;
  texel_t in_val;
  logic [CoordBits-1:0] in_x, in_y;
  assign in_cmd = s_tdata[0];
  assign in_idx = s_tdata[12:1];
  assign in_val = s_tdata[28:13];
  assign in_x = s_tdata[48:29];
  assign in_y = s_tdata[68:49];

  logic acc;
  assign acc = s_tvalid && s_tready;

  // Stage 1: half-pixel shift, weights, neighbor indices.
  logic v1;
  mode_t m1;
  logic [IntBits-1:0] i1, j1;
  logic [SizeBits-1:0] ip1, jp1;
  weight_t a1, b1;
  logic [CoordBits-1:0] xb, yb;
  // Writes travel with the samples so the store sees them in stream order.
  logic w1;
  addr_t widx1;
  texel_t wval1;
  always_comb begin
    xb = linear_filter ? half_back(in_x) : in_x;
    yb = two_dimensional ? (linear_filter ? half_back(in_y) : in_y) : '0;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      w1 <= 1'b0;
    end else if (adv) begin
      v1 <= acc && in_cmd == CmdSample;
      w1 <= acc && in_cmd == CmdWrite;
    end
    if (adv) begin
      m1 <= '{linear: linear_filter, two_dim: two_dimensional};
      i1 <= xb[CoordBits-1:FracBits];
      j1 <= yb[CoordBits-1:FracBits];
      ip1 <= next_of(xb[CoordBits-1:FracBits], tex_width);
      jp1 <= next_of(yb[CoordBits-1:FracBits], tex_height);
      a1 <= linear_filter ? weight_of(xb[FracBits-1:0]) : '0;
      b1 <= two_dimensional && linear_filter ? weight_of(yb[FracBits-1:0]) : '0;
      widx1 <= in_idx;
      wval1 <= in_val;
    end
  end

  // Stage 2: row offsets (one multiply each), saturated addresses.
  logic v2;
  logic [31:0] row0, row1;
  addr_t ad0, ad1, ad2, ad3;
  weight_t a2, b2;
  logic w2;
  addr_t widx2;
  texel_t wval2;
  always_comb begin
    row0 = m1.two_dim ? 32'(j1) * 32'(tex_width) : '0;
    row1 = m1.two_dim ? 32'(jp1) * 32'(tex_width) : '0;
  end
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
      w2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
      w2 <= w1;
    end
    if (adv) begin
      ad0 <= sat_addr(32'(i1) + row0);
      ad1 <= sat_addr(32'(ip1) + row0);
      ad2 <= sat_addr(32'(i1) + row1);
      ad3 <= sat_addr(32'(ip1) + row1);
      a2 <= a1;
      b2 <= b1;
      widx2 <= widx1;
      wval2 <= wval1;
    end
  end

  // Four copies of the store, one per tap; writes go to all.
  texel_t mem0 [TexelDepth], mem1 [TexelDepth], mem2 [TexelDepth], mem3 [TexelDepth];
  logic v3;
  texel_t t0, t1, t2, t3;
  weight_t a3, b3;
  always_ff @(posedge clk) begin
    if (adv && w2) begin
      mem0[widx2] <= wval2;
      mem1[widx2] <= wval2;
      mem2[widx2] <= wval2;
      mem3[widx2] <= wval2;
    end
    if (adv) begin
      t0 <= mem0[ad0];
      t1 <= mem1[ad1];
      t2 <= mem2[ad2];
      t3 <= mem3[ad3];
      a3 <= a2;
      b3 <= b2;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
  end

  // Stage 4: horizontal lerp of both rows (weights sum to 256).
  logic v4;
  logic signed [TexelBits+WeightBits+1:0] h0, h1;
  weight_t b4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      h0 <= $signed({1'b0, 9'd256 - a3}) * t0 + $signed({1'b0, a3}) * t1;
      h1 <= $signed({1'b0, 9'd256 - a3}) * t2 + $signed({1'b0, a3}) * t3;
      b4 <= b3;
    end
  end

  // Stage 5: vertical lerp, rounding, saturation into the output register.
  logic signed [TexelBits+2*WeightBits+3:0] s5, r5;
  always_comb begin
    s5 = $signed({1'b0, 9'd256 - b4}) * h0 + $signed({1'b0, b4}) * h1;
    r5 = (s5 + (1 <<< (2*WeightBits - 1))) >>> (2*WeightBits);
  end
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (adv) m_tvalid <= v4;
    if (adv) begin
      if (r5 > 32767) m_tdata <= 16'h7fff;
      else if (r5 < -32768) m_tdata <= 16'h8000;
      else m_tdata <= r5[15:0];
    end
  end

  `TSF_ASSERT_NEXT(hold_out, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `TSF_ASSERT_IMPL(ready_rule, s_tready, !m_tvalid || m_tready)
  `TSF_ASSERT_NEXT(write_no_v1, acc && s_tdata[0] == CmdWrite, !v1)
endmodule
